// ===== rtl/core/mee_pkg.sv =====
// mee_pkg: shared types, codes and tables of the morse element encoder
// holds the element pattern table and the sequencer microcode rom
// used by mee_decode, morse_element_encoder and the testbench, depends on nothing

package mee_pkg;

   // register index of dot_time_ms (byte address 4 * index) and its reset value
   localparam logic        REG_DOT_TIME   = 1'b0;
   localparam logic [10:0] DOT_TIME_RESET = 11'd100;

   // result kinds
   localparam logic [1:0] KIND_MARK = 2'd0;
   localparam logic [1:0] KIND_GAP  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // element codes inside a packed pattern, first element in bits [1:0]
   localparam logic [1:0] EL_END   = 2'd0;
   localparam logic [1:0] EL_DOT   = 2'd1;
   localparam logic [1:0] EL_DASH  = 2'd2;
   localparam logic [1:0] EL_BLANK = 2'd3;

   localparam int PAT_LEN = 6;
   localparam int PAT_W   = 2 * PAT_LEN;

   // table layout: letters, then digits, then special signs
   localparam logic [5:0] DIGIT_BASE = 6'd26;
   localparam logic [5:0] SIGN_BASE  = 6'd36;
   localparam logic [3:0] SIGN_LAST  = 4'd10;

   // symbol classes
   localparam logic [1:0] CLS_PAT   = 2'd0;
   localparam logic [1:0] CLS_SPACE = 2'd1;
   localparam logic [1:0] CLS_ERR   = 2'd2;

   // decoded symbol, from mee_decode to the sequencer
   typedef struct packed {
      logic [1:0]       cls;
      logic [PAT_W-1:0] pattern;
      logic             char_gap;
   } decode_type;

   // microprogram step addresses
   localparam logic [2:0] STEP_FETCH = 3'd0;
   localparam logic [2:0] STEP_MARK  = 3'd1;
   localparam logic [2:0] STEP_SEP   = 3'd2;
   localparam logic [2:0] STEP_CGAP  = 3'd3;
   localparam logic [2:0] STEP_SPACE = 3'd4;
   localparam logic [2:0] STEP_ERR   = 3'd5;

   // emit gates
   localparam logic [1:0] GATE_NEVER    = 2'd0;
   localparam logic [1:0] GATE_ALWAYS   = 2'd1;
   localparam logic [1:0] GATE_NONBLANK = 2'd2;
   localparam logic [1:0] GATE_CGAP     = 2'd3;

   // unit count sources
   localparam logic [2:0] UNITS_ZERO  = 3'd0;
   localparam logic [2:0] UNITS_ELEM  = 3'd1;
   localparam logic [2:0] UNITS_SEP   = 3'd2;
   localparam logic [2:0] UNITS_THREE = 3'd3;
   localparam logic [2:0] UNITS_SEVEN = 3'd4;

   // last flag sources
   localparam logic [1:0] LAST_NO   = 2'd0;
   localparam logic [1:0] LAST_YES  = 2'd1;
   localparam logic [1:0] LAST_ELEM = 2'd2;

   // jump conditions
   localparam logic [1:0] JC_ALWAYS   = 2'd0;
   localparam logic [1:0] JC_NEXT_END = 2'd1;
   localparam logic [1:0] JC_DISPATCH = 2'd2;

   typedef struct packed {
      logic [1:0] gate;
      logic [1:0] kind;
      logic [2:0] units_sel;
      logic [1:0] last_sel;
      logic       shift;
      logic [1:0] jcond;
      logic [2:0] target;
   } ctrl_word_type;

   // one control word per step
   function automatic ctrl_word_type ucode(input logic [2:0] step);
      ctrl_word_type cw;
      cw = '{GATE_NEVER, KIND_GAP, UNITS_ZERO, LAST_NO, 1'b0, JC_ALWAYS, STEP_FETCH};
      case (step)
         STEP_FETCH: cw = '{GATE_NEVER, KIND_GAP, UNITS_ZERO, LAST_NO, 1'b0,
                            JC_DISPATCH, STEP_FETCH};
         STEP_MARK:  cw = '{GATE_NONBLANK, KIND_MARK, UNITS_ELEM, LAST_ELEM, 1'b0,
                            JC_NEXT_END, STEP_CGAP};
         STEP_SEP:   cw = '{GATE_ALWAYS, KIND_GAP, UNITS_SEP, LAST_NO, 1'b1,
                            JC_ALWAYS, STEP_MARK};
         STEP_CGAP:  cw = '{GATE_CGAP, KIND_GAP, UNITS_THREE, LAST_YES, 1'b0,
                            JC_ALWAYS, STEP_FETCH};
         STEP_SPACE: cw = '{GATE_ALWAYS, KIND_GAP, UNITS_SEVEN, LAST_YES, 1'b0,
                            JC_ALWAYS, STEP_FETCH};
         STEP_ERR:   cw = '{GATE_ALWAYS, KIND_ERR, UNITS_ZERO, LAST_YES, 1'b0,
                            JC_ALWAYS, STEP_FETCH};
         default:    cw = '{GATE_NEVER, KIND_GAP, UNITS_ZERO, LAST_NO, 1'b0,
                            JC_ALWAYS, STEP_FETCH};
      endcase
      return cw;
   endfunction

   // pack six element codes, first one lowest
   function automatic logic [PAT_W-1:0] pack6(input logic [1:0] e0, input logic [1:0] e1,
                                              input logic [1:0] e2, input logic [1:0] e3,
                                              input logic [1:0] e4, input logic [1:0] e5);
      return {e5, e4, e3, e2, e1, e0};
   endfunction

   // element patterns of letters, digits and special signs
   function automatic logic [PAT_W-1:0] pattern_of(input logic [5:0] idx);
      logic [PAT_W-1:0] p;
      p = '0;
      case (idx)
         6'd0:  p = pack6(EL_DOT,  EL_DASH, EL_END,  EL_END,  EL_END,  EL_END);
         6'd1:  p = pack6(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_END,  EL_END);
         6'd2:  p = pack6(EL_DASH, EL_DOT,  EL_DASH, EL_DOT,  EL_END,  EL_END);
         6'd3:  p = pack6(EL_DASH, EL_DOT,  EL_DOT,  EL_END,  EL_END,  EL_END);
         6'd4:  p = pack6(EL_DOT,  EL_END,  EL_END,  EL_END,  EL_END,  EL_END);
         6'd5:  p = pack6(EL_DOT,  EL_DOT,  EL_DASH, EL_DOT,  EL_END,  EL_END);
         6'd6:  p = pack6(EL_DASH, EL_DASH, EL_DOT,  EL_END,  EL_END,  EL_END);
         6'd7:  p = pack6(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_END,  EL_END);
         6'd8:  p = pack6(EL_DOT,  EL_DOT,  EL_END,  EL_END,  EL_END,  EL_END);
         6'd9:  p = pack6(EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_END,  EL_END);
         6'd10: p = pack6(EL_DASH, EL_DOT,  EL_DASH, EL_END,  EL_END,  EL_END);
         6'd11: p = pack6(EL_DOT,  EL_DASH, EL_DOT,  EL_DOT,  EL_END,  EL_END);
         6'd12: p = pack6(EL_DASH, EL_DASH, EL_END,  EL_END,  EL_END,  EL_END);
         6'd13: p = pack6(EL_DASH, EL_DOT,  EL_END,  EL_END,  EL_END,  EL_END);
         6'd14: p = pack6(EL_DASH, EL_DASH, EL_DASH, EL_END,  EL_END,  EL_END);
         6'd15: p = pack6(EL_DOT,  EL_DASH, EL_DASH, EL_DOT,  EL_END,  EL_END);
         6'd16: p = pack6(EL_DASH, EL_DASH, EL_DOT,  EL_DASH, EL_END,  EL_END);
         6'd17: p = pack6(EL_DOT,  EL_DASH, EL_DOT,  EL_END,  EL_END,  EL_END);
         6'd18: p = pack6(EL_DOT,  EL_DOT,  EL_DOT,  EL_END,  EL_END,  EL_END);
         6'd19: p = pack6(EL_DASH, EL_END,  EL_END,  EL_END,  EL_END,  EL_END);
         6'd20: p = pack6(EL_DOT,  EL_DOT,  EL_DASH, EL_END,  EL_END,  EL_END);
         6'd21: p = pack6(EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_END,  EL_END);
         6'd22: p = pack6(EL_DOT,  EL_DASH, EL_DASH, EL_END,  EL_END,  EL_END);
         6'd23: p = pack6(EL_DASH, EL_DOT,  EL_DOT,  EL_DASH, EL_END,  EL_END);
         6'd24: p = pack6(EL_DASH, EL_DOT,  EL_DASH, EL_DASH, EL_END,  EL_END);
         6'd25: p = pack6(EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_END,  EL_END);
         // digits
         6'd26: p = pack6(EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_END);
         6'd27: p = pack6(EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_END);
         6'd28: p = pack6(EL_DOT,  EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_END);
         6'd29: p = pack6(EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_DASH, EL_END);
         6'd30: p = pack6(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_END);
         6'd31: p = pack6(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_END);
         6'd32: p = pack6(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_END);
         6'd33: p = pack6(EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_END);
         6'd34: p = pack6(EL_DASH, EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_END);
         6'd35: p = pack6(EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DOT,  EL_END);
         // special signs
         6'd36: p = pack6(EL_DOT,  EL_DOT,  EL_DASH, EL_DASH, EL_DOT,  EL_DOT);
         6'd37: p = pack6(EL_DOT,  EL_DASH, EL_DOT,  EL_DASH, EL_DOT,  EL_DASH);
         6'd38: p = pack6(EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_DASH, EL_DASH);
         6'd39: p = pack6(EL_DASH, EL_DOT,  EL_DOT,  EL_DASH, EL_DOT,  EL_END);
         6'd40: p = pack6(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_END);
         6'd41: p = pack6(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH);
         6'd42: p = pack6(EL_DASH, EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_END);
         6'd43: p = pack6(EL_DOT,  EL_DOT,  EL_BLANK, EL_DOT, EL_DOT,  EL_END);
         6'd44: p = pack6(EL_DOT,  EL_DASH, EL_DASH, EL_DOT,  EL_DASH, EL_END);
         6'd45: p = pack6(EL_DOT,  EL_DASH, EL_DOT,  EL_DASH, EL_END,  EL_END);
         6'd46: p = pack6(EL_DASH, EL_DASH, EL_DASH, EL_DOT,  EL_END,  EL_END);
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/core/mee_decode.sv =====
// mee_decode: classifies one request symbol and looks up its element pattern
// depends on mee_pkg (pattern table, class codes, decode_type)

module mee_decode (
   input  logic [7:0]          symbol,
   input  logic                is_special,
   input  logic [3:0]          special_index,
   input  logic                next_is_space,
   output mee_pkg::decode_type dec
);

   logic [7:0] sym_fold;
   logic [5:0] tab_idx;

   // fold lower case onto upper case
   assign sym_fold = (symbol inside {[8'h61:8'h7A]}) ? (symbol - 8'd32) : symbol;

   // class, table index and character gap
   always_comb begin
      dec.cls      = mee_pkg::CLS_ERR;
      dec.char_gap = 1'b0;
      tab_idx      = '0;
      if (is_special) begin
         if (special_index <= mee_pkg::SIGN_LAST) begin
            dec.cls = mee_pkg::CLS_PAT;
            tab_idx = mee_pkg::SIGN_BASE + {2'b00, special_index};
         end
      end else if (sym_fold == 8'h20) begin
         dec.cls = mee_pkg::CLS_SPACE;
      end else if (sym_fold inside {[8'h30:8'h39]}) begin
         dec.cls      = mee_pkg::CLS_PAT;
         dec.char_gap = ~next_is_space;
         tab_idx      = mee_pkg::DIGIT_BASE + 6'(sym_fold - 8'h30);
      end else if (sym_fold inside {[8'h41:8'h5A]}) begin
         dec.cls      = mee_pkg::CLS_PAT;
         dec.char_gap = ~next_is_space;
         tab_idx      = 6'(sym_fold - 8'h41);
      end
      dec.pattern = mee_pkg::pattern_of(tab_idx);
   end

endmodule

// ===== rtl/core/morse_element_encoder.sv =====
// morse_element_encoder: top level, apb register, microcoded sequencer, output register
// depends on mee_pkg and mee_decode

// One request (a symbol) is taken while the sequencer sits in its fetch step;
// it then yields its timed elements, at most one result per sequencer step, each held
// in an output register until the result channel takes it. A letter or digit
// of n elements passes through fetch, n mark steps, n-1 separator steps and
// one character gap step, a special sign likewise, a space or an unknown
// symbol through fetch and one space or error step. The sequencer issues one
// microcode step per cycle, and outside the fetch step any cycle in which
// a finished result is stalled holds it. Durations are units times
// dot_time_ms (register 0 at byte address 0), truncated to 14 bits.

module morse_element_encoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_symbol,
   input  logic        req_is_special,
   input  logic [3:0]  req_special_index,
   input  logic        req_next_is_space,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_element_kind,
   output logic [13:0] rsp_duration_ms,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [10:0]                  dot_ff, dot_in;
   logic [2:0]                   pc_ff, pc_in;
   logic [mee_pkg::PAT_W-1:0]    pat_ff, pat_in;
   logic                         cgap_ff, cgap_in;
   logic                         out_valid_ff, out_valid_in;
   logic [1:0]                   out_kind_ff, out_kind_in;
   logic [13:0]                  out_dur_ff, out_dur_in;
   logic                         out_last_ff, out_last_in;

   mee_pkg::decode_type          dec;
   mee_pkg::ctrl_word_type       cw;
   logic [1:0]                   elem, nxt;
   logic                         hold, emit, jump, accept;
   logic [2:0]                   units;
   logic [13:0]                  product;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == mee_pkg::REG_DOT_TIME) ? {21'b0, dot_ff} : 32'b0;
   assign dot_in = (psel && penable && pwrite && paddr[2] == mee_pkg::REG_DOT_TIME) ?
                   pwdata[10:0] : dot_ff;

   mee_decode u_decode (
      .symbol        (req_symbol),
      .is_special    (req_is_special),
      .special_index (req_special_index),
      .next_is_space (req_next_is_space),
      .dec           (dec)
   );

   // control word of the current step
   assign cw     = mee_pkg::ucode(pc_ff);
   assign elem   = pat_ff[1:0];
   assign nxt    = pat_ff[3:2];
   assign hold   = (pc_ff != mee_pkg::STEP_FETCH) && out_valid_ff && rsp_stall;
   assign req_stall = (pc_ff != mee_pkg::STEP_FETCH);
   assign accept = req_valid && !req_stall;

   // emit gate
   always_comb begin
      case (cw.gate)
         mee_pkg::GATE_ALWAYS:   emit = 1'b1;
         mee_pkg::GATE_NONBLANK: emit = (elem != mee_pkg::EL_BLANK);
         mee_pkg::GATE_CGAP:     emit = cgap_ff;
         default:                emit = 1'b0;
      endcase
   end

   // unit count
   always_comb begin
      case (cw.units_sel)
         mee_pkg::UNITS_ELEM:  units = (elem == mee_pkg::EL_DASH) ? 3'd3 : 3'd1;
         mee_pkg::UNITS_SEP:   units = (nxt == mee_pkg::EL_BLANK) ? 3'd2 : 3'd1;
         mee_pkg::UNITS_THREE: units = 3'd3;
         mee_pkg::UNITS_SEVEN: units = 3'd7;
         default:              units = 3'd0;
      endcase
   end

   assign product = 14'({3'b000, dot_ff} * {11'b0, units});

   // jump condition
   always_comb begin
      case (cw.jcond)
         mee_pkg::JC_ALWAYS:   jump = 1'b1;
         mee_pkg::JC_NEXT_END: jump = (nxt == mee_pkg::EL_END);
         default:              jump = 1'b0;
      endcase
   end

   // sequencer next state
   always_comb begin
      pc_in   = pc_ff;
      pat_in  = pat_ff;
      cgap_in = cgap_ff;
      if (cw.jcond == mee_pkg::JC_DISPATCH) begin
         if (accept) begin
            pat_in  = dec.pattern;
            cgap_in = dec.char_gap;
            case (dec.cls)
               mee_pkg::CLS_PAT:   pc_in = mee_pkg::STEP_MARK;
               mee_pkg::CLS_SPACE: pc_in = mee_pkg::STEP_SPACE;
               default:            pc_in = mee_pkg::STEP_ERR;
            endcase
         end
      end else if (!hold) begin
         pc_in = jump ? cw.target : 3'(pc_ff + 3'd1);
         if (cw.shift) begin
            pat_in = {2'b00, pat_ff[mee_pkg::PAT_W-1:2]};
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_dur_in   = out_dur_ff;
      out_last_in  = out_last_ff;
      if (!hold && emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = cw.kind;
         out_dur_in   = product;
         case (cw.last_sel)
            mee_pkg::LAST_YES:  out_last_in = 1'b1;
            mee_pkg::LAST_ELEM: out_last_in = (nxt == mee_pkg::EL_END) && !cgap_ff;
            default:            out_last_in = 1'b0;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff       <= mee_pkg::DOT_TIME_RESET;
         pc_ff        <= mee_pkg::STEP_FETCH;
         out_valid_ff <= 1'b0;
      end else begin
         dot_ff       <= dot_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pat_ff      <= pat_in;
      cgap_ff     <= cgap_in;
      out_kind_ff <= out_kind_in;
      out_dur_ff  <= out_dur_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_element_kind = out_kind_ff;
   assign rsp_duration_ms  = out_dur_ff;
   assign rsp_last         = out_last_ff;

   // checks
   a_accept_leaves_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> pc_ff != mee_pkg::STEP_FETCH)
      else $error("sequencer stayed in fetch after taking a request");

   a_sep_not_at_end: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == mee_pkg::STEP_SEP && !hold) |-> nxt != mee_pkg::EL_END)
      else $error("separator step reached the end of a pattern");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_element_kind == mee_pkg::KIND_ERR) |->
         (rsp_last && rsp_duration_ms == 14'd0))
      else $error("error result without last flag or with a duration");

   a_hold_keeps_step: assert property (@(posedge clock) disable iff (reset)
      hold |=> $stable(pc_ff))
      else $error("sequencer moved while a result was stalled");

endmodule

// ===== tb/sv/morse_element_checker.sv =====
// morse_element_checker: watches the request, result and register ports of the encoder
// predicts the timed morse elements of each symbol and compares them in order
// depends on mee_pkg for the result kind codes and the register layout

module morse_element_checker (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_symbol,
   input  logic        req_is_special,
   input  logic [3:0]  req_special_index,
   input  logic        req_next_is_space,
   // result channel
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_element_kind,
   input  logic [13:0] rsp_duration_ms,
   input  logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   // status toward the stimulus
   output int          owed,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [13:0] duration;
      logic        last;
   } element_type;

   // dots, dashes and blanks of every symbol, in the encoder's order
   string letter_code [26] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
   string digit_code [10] = '{
      "-----", ".----", "..---", "...--", "....-",
      ".....", "-....", "--...", "---..", "----."};
   string sign_code [11] = '{
      "..--..", ".-.-.-", "--..--", "-..-.", "-...-", "-....-",
      "-.---", ".. ..", ".--.-", ".-.-", "---."};

   logic [10:0] dot_time;
   element_type owed_elements [$];
   element_type staged [0:15];
   int          staged_n;

   // one element of the symbol being encoded, duration truncated to 14 bits
   function automatic void stage_element(input logic [1:0] kind, input int units);
      logic [31:0] product;
      product = units * dot_time;
      staged[staged_n] = '{kind: kind, duration: product[13:0], last: 1'b0};
      staged_n++;
   endfunction

   // marks with their inner gaps; a blank widens the gap ahead of it and adds its own
   function automatic void stage_code(input string code);
      for (int j = 0; j < code.len(); j++) begin
         if (code[j] == ".") begin
            stage_element(mee_pkg::KIND_MARK, 1);
         end else if (code[j] == "-") begin
            stage_element(mee_pkg::KIND_MARK, 3);
         end
         if (j + 1 < code.len()) begin
            stage_element(mee_pkg::KIND_GAP, (code[j + 1] == " ") ? 2 : 1);
         end
      end
   endfunction

   // expected elements of one symbol, appended to the owed list
   function automatic void encode_symbol(input logic [7:0] sym, input logic special,
                                         input logic [3:0] sign, input logic next_space);
      logic [7:0] ch;
      ch = sym;
      staged_n = 0;
      if (special) begin
         if (sign <= mee_pkg::SIGN_LAST) begin
            stage_code(sign_code[sign]);
         end
      end else if (ch == " ") begin
         stage_element(mee_pkg::KIND_GAP, 7);
      end else begin
         if (ch >= "a" && ch <= "z") begin
            ch = ch - 8'd32;
         end
         if ((ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z")) begin
            if (ch <= "9") begin
               stage_code(digit_code[ch - "0"]);
            end else begin
               stage_code(letter_code[ch - "A"]);
            end
            if (!next_space) begin
               stage_element(mee_pkg::KIND_GAP, 3);
            end
         end
      end
      // anything unknown gives a single error element
      if (staged_n == 0) begin
         stage_element(mee_pkg::KIND_ERR, 0);
      end
      staged[staged_n - 1].last = 1'b1;
      for (int i = 0; i < staged_n; i++) begin
         owed_elements.push_back(staged[i]);
      end
   endfunction

   // compare one accepted result with the oldest owed element
   task automatic check_element();
      element_type want;
      if (owed_elements.size() == 0) begin
         $display("%0t: unexpected result kind %0d duration %0d last %0d", $time,
                  rsp_element_kind, rsp_duration_ms, rsp_last);
         fail_count++;
      end else begin
         want = owed_elements.pop_front();
         if (rsp_element_kind !== want.kind) begin
            $display("%0t: element kind expected %0d got %0d", $time, want.kind,
                     rsp_element_kind);
            fail_count++;
         end
         if (rsp_duration_ms !== want.duration) begin
            $display("%0t: duration expected %0d got %0d", $time, want.duration,
                     rsp_duration_ms);
            fail_count++;
         end
         if (rsp_last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, rsp_last);
            fail_count++;
         end
      end
   endtask

   // follow register traffic, predict requests, check results
   always @(posedge clock) begin
      if (reset) begin
         owed_elements.delete();
         dot_time = mee_pkg::DOT_TIME_RESET;
         fail_count = 0;
         owed <= 0;
      end else begin
         if (psel && penable && pready && paddr[2] == mee_pkg::REG_DOT_TIME) begin
            if (pwrite) begin
               dot_time = pwdata[10:0];
            end else if (prdata[10:0] !== dot_time) begin
               $display("%0t: dot time read expected %0d got %0d", $time, dot_time,
                        prdata[10:0]);
               fail_count++;
            end
         end
         if (req_valid && !req_stall) begin
            encode_symbol(req_symbol, req_is_special, req_special_index, req_next_is_space);
         end
         if (rsp_valid && !rsp_stall) begin
            check_element();
         end
         owed <= owed_elements.size();
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: clock, reset and stimulus for the morse element encoder, plus the verdict
// depends on morse_element_encoder, morse_element_checker and mee_pkg

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         PHASE_ITEMS   = 73;
   localparam int         PHASES        = 6;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         IDLE_PERCENT  = 24;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_symbol;
   logic        req_is_special;
   logic [3:0]  req_special_index;
   logic        req_next_is_space;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_element_kind;
   logic [13:0] rsp_duration_ms;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int   owed;
   int   fail_count;
   int   cycle_count = 0;
   logic steady;

   morse_element_encoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol        (req_symbol),
      .req_is_special    (req_is_special),
      .req_special_index (req_special_index),
      .req_next_is_space (req_next_is_space),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_kind  (rsp_element_kind),
      .rsp_duration_ms   (rsp_duration_ms),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   morse_element_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol        (req_symbol),
      .req_is_special    (req_is_special),
      .req_special_index (req_special_index),
      .req_next_is_space (req_next_is_space),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_kind  (rsp_element_kind),
      .rsp_duration_ms   (rsp_duration_ms),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .owed              (owed),
      .fail_count        (fail_count)
   );

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
   end

   // one request, at times with a random gap ahead of it; valid stays high afterwards
   task automatic send_request(input logic [7:0] sym, input logic special,
                               input logic [3:0] sign, input logic next_space);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_symbol        <= sym;
      req_is_special    <= special;
      req_special_index <= sign;
      req_next_is_space <= next_space;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly real symbols, some broken signs and raw bytes
   task automatic send_random_symbol();
      int          pick;
      logic [7:0]  sym;
      logic        special;
      logic [3:0]  sign;
      pick    = int'($urandom_range(99));
      sym     = 8'($urandom_range(255));
      special = 1'b0;
      sign    = 4'($urandom_range(15));
      if (pick < 35) begin
         sym = 8'("A" + $urandom_range(25));
      end else if (pick < 50) begin
         sym = 8'("a" + $urandom_range(25));
      end else if (pick < 65) begin
         sym = 8'("0" + $urandom_range(9));
      end else if (pick < 75) begin
         sym = " ";
      end else if (pick < 88) begin
         special = 1'b1;
         sign    = 4'($urandom_range(mee_pkg::SIGN_LAST));
      end else if (pick < 94) begin
         special = 1'b1;
      end
      send_request(sym, special, sign, 1'($urandom_range(1)));
   endtask

   // wait until every owed element is out, then let the block go quiet
   task automatic wait_drained(input int settle);
      @(posedge clock);
      while (owed != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // register access: setup cycle then access cycle
   task automatic access_dot_time(input logic write, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {mee_pkg::REG_DOT_TIME, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // directed symbols, then random phases over several unit lengths
   initial begin
      logic [31:0] dot_plan [PHASES];
      dot_plan = '{32'd100, 32'd1, 32'd1200, 32'd0, 32'd2047, 32'd0};
      steady            = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_symbol        <= 8'd0;
      req_is_special    <= 1'b0;
      req_special_index <= 4'd0;
      req_next_is_space <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= 3'd0;
      pwdata            <= 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      access_dot_time(1'b0, 32'd0);

      // letters, lower case, digits, space, unknown bytes, every special sign
      send_request("A", 1'b0, 4'd0, 1'b0);
      send_request("z", 1'b0, 4'd15, 1'b1);
      send_request("0", 1'b0, 4'd0, 1'b0);
      send_request("9", 1'b0, 4'd0, 1'b1);
      send_request(" ", 1'b0, 4'd15, 1'b1);
      send_request("&", 1'b0, 4'd0, 1'b0);
      send_request(8'hFF, 1'b0, 4'd0, 1'b0);
      send_request(8'h00, 1'b0, 4'd0, 1'b1);
      for (int s = 0; s <= 15; s++) begin
         send_request(8'hFF, 1'b1, s[3:0], s[0]);
      end
      req_valid <= 1'b0;
      wait_drained(SETTLE_CYCLES);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            if (phase == PHASES - 1) begin
               dot_plan[phase] = $urandom_range(1200, 1);
            end
            access_dot_time(1'b1, dot_plan[phase]);
            access_dot_time(1'b0, 32'd0);
         end
         // one phase with no idling on either side
         steady = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               wait_drained(0);
            end
            send_random_symbol();
         end
         req_valid <= 1'b0;
         wait_drained(SETTLE_CYCLES);
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mee_pkg.sv
rtl/core/mee_decode.sv
rtl/core/morse_element_encoder.sv
tb/sv/morse_element_checker.sv
tb/sv/tb_top.sv
